>>> rtl/lwps_pkg.sv
// Package for the window pixel stream block.
// Holds the transaction types, opcode and command codes shared by all rtl files.
// No dependencies.
package lwps_pkg;

  typedef enum logic [1:0] {
    OP_REGION = 2'd0,
    OP_FRAME  = 2'd1,
    OP_PIXEL  = 2'd2
  } opcode_t;

  localparam logic [7:0] CMD_COL_SET = 8'h2a;
  localparam logic [7:0] CMD_ROW_SET = 8'h2b;
  localparam logic [7:0] CMD_MEM_WR  = 8'h2c;

  localparam logic [0:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [0:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [15:0] FRAME_WIDTH_RESET  = 16'd240;
  localparam logic [15:0] FRAME_HEIGHT_RESET = 16'd240;

  localparam int WIN_BYTES   = 11;
  localparam int IDX_W       = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] reg_x;
    logic [15:0] reg_y;
    logic [15:0] reg_w;
    logic [15:0] reg_h;
    logic [23:0] pixel_rgb;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_command;
    logic       burst_end;
    logic       overrun;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    JOB_WINDOW  = 2'd0,
    JOB_PIXEL   = 2'd1,
    JOB_OVERRUN = 2'd2
  } job_kind_t;

  // window: word[0..3] = x first, x last, y first, y last
  // pixel: word[0] = {high byte, low byte}, end_flag on the final pixel
  typedef struct packed {
    job_kind_t        kind;
    logic [3:0][15:0] word;
    logic             end_flag;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_head_t;

endpackage

>>> rtl/lcd_window_pixel_stream_core.sv
// Top level of the window pixel stream block.
// Ties front end, job queue and back end together. Depends on lwps_pkg.
//
// Input channel (in_valid/in_ready/in_item): region start, full-frame start
// or one 24-bit pixel. Output channel (out_valid/out_ready/out_item): one
// link byte per transaction with command, burst end, overrun and last flags.
// A start yields eleven bytes (column set, row set, memory write); a pixel
// yields two RGB565 bytes, high first; a pixel with no count left yields one
// overrun transaction; opcode 3 yields nothing.
// Configuration: cfg_we writes cfg_data to frame width (index 0) or frame
// height (index 1); both reset to 240.
// An accepted transaction passes through the job queue and then the output
// register. The output carries one byte per cycle while the receiver takes
// them; the single byte-wide output register sets this rate.
// A two-entry job queue lets the front end keep accepting while the back end
// drains. When the receiver stalls, the output holds, the queue fills and
// in_ready drops. Reset empties the queue, clears the pixel count and
// restores the frame registers.
module lcd_window_pixel_stream_core #(
  parameter int COORD_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  lwps_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output lwps_pkg::out_item_t out_item
);
  import lwps_pkg::*;

  logic      q_ready;
  logic      push;
  job_t      push_job;
  job_head_t head;
  logic      pop;

  lwps_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_ready  (q_ready),
    .push     (push),
    .push_job (push_job)
  );

  lwps_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .ready   (q_ready),
    .head    (head),
    .pop     (pop)
  );

  lwps_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule

>>> rtl/lwps_front.sv
// Front end: accepts input transactions, holds frame registers and pixel count.
// Classifies each transaction into a job for the queue; opcode 3 yields none. Depends on lwps_pkg.
module lwps_front #(
  parameter int COORD_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  lwps_pkg::in_item_t in_item,
  input  logic             q_ready,
  output logic             push,
  output lwps_pkg::job_t   push_job
);
  import lwps_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int PIX_W = 2 * COORD_BITS;

  logic [15:0]      frame_width;
  logic [15:0]      frame_height;
  logic [PIX_W-1:0] pixels_left;
  logic [PIX_W-1:0] pixels_left_next;

  logic [CB-1:0]    x_first;
  logic [CB-1:0]    y_first;
  logic [CB-1:0]    size_w;
  logic [CB-1:0]    size_h;
  logic [CB-1:0]    x_last;
  logic [CB-1:0]    y_last;
  logic [PIX_W-1:0] area;
  logic [7:0]       px_hi;
  logic [7:0]       px_lo;
  logic             accept;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (in_item.opcode == OP_REGION) begin
      x_first = in_item.reg_x[CB-1:0];
      y_first = in_item.reg_y[CB-1:0];
      size_w  = in_item.reg_w[CB-1:0];
      size_h  = in_item.reg_h[CB-1:0];
    end else begin
      x_first = '0;
      y_first = '0;
      size_w  = frame_width[CB-1:0];
      size_h  = frame_height[CB-1:0];
    end
  end

  assign x_last = x_first + size_w - CB'(1);
  assign y_last = y_first + size_h - CB'(1);
  assign area   = PIX_W'(size_w) * PIX_W'(size_h);
  assign px_hi  = {in_item.pixel_rgb[23:19], in_item.pixel_rgb[15:13]};
  assign px_lo  = {in_item.pixel_rgb[12:10], in_item.pixel_rgb[7:3]};

  always_comb begin
    push             = 1'b0;
    push_job.kind    = JOB_WINDOW;
    push_job.word    = '0;
    push_job.end_flag = 1'b0;
    pixels_left_next = pixels_left;
    if (accept) begin
      unique case (in_item.opcode)
        OP_REGION, OP_FRAME: begin
          push             = 1'b1;
          push_job.kind    = JOB_WINDOW;
          push_job.word[0] = 16'(x_first);
          push_job.word[1] = 16'(x_last);
          push_job.word[2] = 16'(y_first);
          push_job.word[3] = 16'(y_last);
          pixels_left_next = area;
        end
        OP_PIXEL: begin
          push = 1'b1;
          if (pixels_left == '0) begin
            push_job.kind = JOB_OVERRUN;
          end else begin
            push_job.kind     = JOB_PIXEL;
            push_job.word[0]  = {px_hi, px_lo};
            push_job.end_flag = (pixels_left == PIX_W'(1));
            pixels_left_next  = pixels_left - PIX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixels_left <= '0;
    end else begin
      pixels_left <= pixels_left_next;
    end
  end

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (accept && in_item.opcode == OP_PIXEL && pixels_left != '0)
      |=> pixels_left == $past(pixels_left) - PIX_W'(1))
    else $error("pixel count did not step down");

endmodule

>>> rtl/lwps_queue.sv
// Short job queue between front and back ends.
// Two entries in flip-flops, head shown combinationally. Depends on lwps_pkg.
module lwps_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lwps_pkg::job_t      push_job,
  output logic                ready,
  output lwps_pkg::job_head_t head,
  input  logic                pop
);
  import lwps_pkg::*;

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign ready      = (count != QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    push |-> ready)
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("job popped from an empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

>>> rtl/lwps_back.sv
// Back end: expands the head job into link bytes and drives the output register.
// One byte per cycle while the receiver takes them. Depends on lwps_pkg.
module lwps_back (
  input  logic                clk,
  input  logic                rst,
  input  lwps_pkg::job_head_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output lwps_pkg::out_item_t out_item
);
  import lwps_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             load;
  logic             emit;
  logic             final_byte;
  out_item_t        item_next;

  assign load = !out_valid || out_ready;
  assign emit = load && head.valid;
  assign pop  = emit && final_byte;

  always_comb begin
    item_next  = '0;
    final_byte = 1'b0;
    unique case (head.job.kind)
      JOB_WINDOW: begin
        item_next.burst_end = 1'b1;
        unique case (idx)
          4'd0: begin
            item_next.out_byte   = CMD_COL_SET;
            item_next.is_command = 1'b1;
          end
          4'd1: item_next.out_byte = head.job.word[0][15:8];
          4'd2: item_next.out_byte = head.job.word[0][7:0];
          4'd3: item_next.out_byte = head.job.word[1][15:8];
          4'd4: item_next.out_byte = head.job.word[1][7:0];
          4'd5: begin
            item_next.out_byte   = CMD_ROW_SET;
            item_next.is_command = 1'b1;
          end
          4'd6: item_next.out_byte = head.job.word[2][15:8];
          4'd7: item_next.out_byte = head.job.word[2][7:0];
          4'd8: item_next.out_byte = head.job.word[3][15:8];
          4'd9: item_next.out_byte = head.job.word[3][7:0];
          default: begin
            item_next.out_byte   = CMD_MEM_WR;
            item_next.is_command = 1'b1;
            final_byte           = 1'b1;
          end
        endcase
      end
      JOB_PIXEL: begin
        if (idx == '0) begin
          item_next.out_byte = head.job.word[0][15:8];
        end else begin
          item_next.out_byte  = head.job.word[0][7:0];
          item_next.burst_end = head.job.end_flag;
          final_byte          = 1'b1;
        end
      end
      default: begin
        item_next.overrun = 1'b1;
        final_byte        = 1'b1;
      end
    endcase
    item_next.last = final_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= head.valid;
      end
      if (emit) begin
        idx <= final_byte ? '0 : idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= item_next;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= IDX_W'(WIN_BYTES - 1))
    else $error("byte index out of range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !pop ##1 $stable(idx))
    else $error("back end advanced while output stalled");

endmodule

>>> dv/tb_lcd_window_pixel_stream_core.sv
// Testbench for lcd_window_pixel_stream_core: window starts and pixels in, link bytes out.
// A directed table runs first, then random window sequences, noise and frame size changes.
// Every output transaction is checked against a local predictor. Depends on lwps_pkg.
`timescale 1ns / 1ps

module tb_lcd_window_pixel_stream_core;
  import lwps_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RAND_ITEMS = 170;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD_CYCLES = 80;

  localparam out_item_t OVERRUN_OUT = {8'h00, 1'b0, 1'b0, 1'b1, 1'b1};
  localparam out_item_t COL_SET_OUT = {CMD_COL_SET, 1'b1, 1'b1, 1'b0, 1'b0};

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    in_item_t    item;
    bit          has_first;
    out_item_t   first_out;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;

  out_item_t   pending_bytes[$];
  stim_row_t   directed_rows[$];

  logic [15:0] model_frame_w;
  logic [15:0] model_frame_h;
  logic [31:0] model_pixels_left;

  int err_count;
  int items_sent;
  int directed_items;
  int results_seen;
  int overruns_seen;
  int cfg_writes;
  int burst_left;
  bit hold_request;
  bit hold_served;
  bit paused_once;

  lcd_window_pixel_stream_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("lcd_window_pixel_stream_core test failed");
    $finish;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
  endtask

  function automatic void push_byte(logic [7:0] b, logic cmd, logic bend, logic ovr,
                                    logic lst);
    pending_bytes.push_back({b, cmd, bend, ovr, lst});
  endfunction

  function automatic void predict_axis(logic [7:0] cmd, logic [15:0] pos, logic [15:0] size);
    logic [15:0] stop;
    stop = pos + size - 16'd1;
    push_byte(cmd, 1'b1, 1'b1, 1'b0, 1'b0);
    push_byte(pos[15:8], 1'b0, 1'b1, 1'b0, 1'b0);
    push_byte(pos[7:0], 1'b0, 1'b1, 1'b0, 1'b0);
    push_byte(stop[15:8], 1'b0, 1'b1, 1'b0, 1'b0);
    push_byte(stop[7:0], 1'b0, 1'b1, 1'b0, 1'b0);
  endfunction

  function automatic void predict_window(logic [15:0] x, logic [15:0] y, logic [15:0] w,
                                         logic [15:0] h);
    predict_axis(CMD_COL_SET, x, w);
    predict_axis(CMD_ROW_SET, y, h);
    push_byte(CMD_MEM_WR, 1'b1, 1'b1, 1'b0, 1'b1);
    model_pixels_left = 32'(w) * 32'(h);
  endfunction

  function automatic void predict_item(in_item_t it);
    logic [7:0] hi;
    logic [7:0] lo;
    case (it.opcode)
      OP_REGION: predict_window(it.reg_x, it.reg_y, it.reg_w, it.reg_h);
      OP_FRAME:  predict_window(16'd0, 16'd0, model_frame_w, model_frame_h);
      OP_PIXEL: begin
        if (model_pixels_left == 32'd0) begin
          push_byte(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
        end else begin
          hi = {it.pixel_rgb[23:19], it.pixel_rgb[15:13]};
          lo = {it.pixel_rgb[12:10], it.pixel_rgb[7:3]};
          model_pixels_left = model_pixels_left - 32'd1;
          push_byte(hi, 1'b0, 1'b0, 1'b0, 1'b0);
          push_byte(lo, 1'b0, model_pixels_left == 32'd0, 1'b0, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic in_item_t mk_item(logic [1:0] op, logic [15:0] x, logic [15:0] y,
                                       logic [15:0] w, logic [15:0] h, logic [23:0] rgb);
    in_item_t it;
    it.opcode = op;
    it.reg_x = x;
    it.reg_y = y;
    it.reg_w = w;
    it.reg_h = h;
    it.pixel_rgb = rgb;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    return mk_item(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 24'($urandom));
  endfunction

  function automatic logic [15:0] pick_size();
    int r;
    r = $urandom_range(0, 19);
    if (r < 17) return 16'($urandom_range(1, 4));
    if (r == 17) return 16'd0;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_frame_dim();
    case ($urandom_range(0, 5))
      0: return 16'd1;
      1: return 16'hffff;
      2: return 16'd240;
      default: return 16'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic void add_item(in_item_t it, bit has_first = 1'b0,
                                   out_item_t first_out = '0);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.item = it;
    row.has_first = has_first;
    row.first_out = first_out;
    row.cfg_index = '0;
    row.cfg_data = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic [0:0] idx, logic [15:0] data);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.item = '0;
    row.has_first = 1'b0;
    row.first_out = '0;
    row.cfg_index = idx;
    row.cfg_data = data;
    directed_rows.push_back(row);
  endfunction

  // Sender paces itself in bursts; a long burst now and then leaves stretches with no gaps.
  task automatic pace();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_item(in_item_t it, bit has_first, out_item_t first_out);
    int base;
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    base = pending_bytes.size();
    predict_item(it);
    if (has_first && pending_bytes.size() > base) pending_bytes[base] = first_out;
    if (it.opcode != OP_UNUSED) items_sent++;
    pace();
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [0:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FRAME_WIDTH) model_frame_w = data;
    else model_frame_h = data;
    cfg_writes++;
  endtask

  task automatic run_window_sequence();
    in_item_t it;
    int planned;
    it = rand_item();
    if ($urandom_range(0, 4) == 0) begin
      it.opcode = OP_FRAME;
    end else begin
      it.opcode = OP_REGION;
      it.reg_w = pick_size();
      it.reg_h = pick_size();
    end
    send_item(it, 1'b0, '0);
    planned = (model_pixels_left > 32'd12) ? $urandom_range(1, 12) : int'(model_pixels_left);
    case ($urandom_range(0, 9))
      0, 1: planned += $urandom_range(1, 2);
      2: if (planned > 1) planned = $urandom_range(1, planned - 1);
      default: ;
    endcase
    repeat (planned) begin
      it = rand_item();
      it.opcode = OP_PIXEL;
      send_item(it, 1'b0, '0);
    end
  endtask

  // Receiver: rotate through stall patterns, with one long hold-off on request.
  always begin : rx_pattern
    int rx_cycle;
    logic rdy;
    @(negedge clk);
    if (hold_request && !hold_served) begin
      out_ready <= 1'b0;
      repeat (LONG_HOLD_CYCLES) @(negedge clk);
      hold_served = 1'b1;
    end
    rx_cycle++;
    case ((rx_cycle / 40) % 4)
      0: rdy = 1'b1;
      1: rdy = ($urandom_range(0, 1) == 0);
      2: rdy = (rx_cycle % 3 != 0);
      default: rdy = ($urandom_range(0, 4) != 0);
    endcase
    out_ready <= rdy;
  end

  always @(posedge clk) begin : check_outputs
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (out_item.overrun) overruns_seen++;
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected transaction", 32'(out_item), 32'd0);
      end else begin
        want = pending_bytes.pop_front();
        if (out_item.out_byte !== want.out_byte)
          report_mismatch("out_byte", 32'(out_item.out_byte), 32'(want.out_byte));
        if (out_item.is_command !== want.is_command)
          report_mismatch("is_command", 32'(out_item.is_command), 32'(want.is_command));
        if (out_item.burst_end !== want.burst_end)
          report_mismatch("burst_end", 32'(out_item.burst_end), 32'(want.burst_end));
        if (out_item.overrun !== want.overrun)
          report_mismatch("overrun", 32'(out_item.overrun), 32'(want.overrun));
        if (out_item.last !== want.last)
          report_mismatch("last", 32'(out_item.last), 32'(want.last));
      end
    end
  end

  initial begin
    int sel;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    model_frame_w = FRAME_WIDTH_RESET;
    model_frame_h = FRAME_HEIGHT_RESET;
    model_pixels_left = 32'd0;

    add_item(mk_item(OP_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 24'habcdef), 1'b1, OVERRUN_OUT);
    add_item(mk_item(OP_UNUSED, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 24'hffffff));
    add_item(mk_item(OP_FRAME, 16'h0, 16'h0, 16'h0, 16'h0, 24'h0), 1'b1, COL_SET_OUT);
    add_item(mk_item(OP_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 24'hffffff), 1'b1,
             {8'hff, 4'b0000});
    add_item(mk_item(OP_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 24'h000000), 1'b1,
             {8'h00, 4'b0000});
    add_item(mk_item(OP_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 24'h5a5a5a));
    add_item(mk_item(OP_REGION, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 24'h0), 1'b1,
             COL_SET_OUT);
    add_item(mk_item(OP_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 24'hf80000));
    add_item(mk_item(OP_REGION, 16'h0, 16'h0, 16'h0, 16'h0, 24'h0), 1'b1, COL_SET_OUT);
    add_item(mk_item(OP_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 24'h123456), 1'b1, OVERRUN_OUT);
    add_item(mk_item(OP_REGION, 16'h0012, 16'h0034, 16'h0, 16'h3, 24'h0));
    add_item(mk_item(OP_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 24'h00ff00), 1'b1, OVERRUN_OUT);
    add_item(mk_item(OP_REGION, 16'h1, 16'h2, 16'h1, 16'h2, 24'h0));
    add_item(mk_item(OP_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 24'h0007e0));
    add_item(mk_item(OP_REGION, 16'h5, 16'h6, 16'h1, 16'h1, 24'h0));
    add_item(mk_item(OP_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 24'h00fc00));
    add_item(mk_item(OP_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 24'h0000ff), 1'b1, OVERRUN_OUT);
    add_cfg(REG_FRAME_WIDTH, 16'd1);
    add_cfg(REG_FRAME_HEIGHT, 16'd1);
    add_item(mk_item(OP_FRAME, 16'h0, 16'h0, 16'h0, 16'h0, 24'h0));
    add_item(mk_item(OP_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 24'hffffff));
    add_item(mk_item(OP_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 24'h808080), 1'b1, OVERRUN_OUT);
    add_cfg(REG_FRAME_WIDTH, 16'hffff);
    add_cfg(REG_FRAME_HEIGHT, 16'hffff);
    add_item(mk_item(OP_FRAME, 16'h0, 16'h0, 16'h0, 16'h0, 24'h0), 1'b1, COL_SET_OUT);
    add_item(mk_item(OP_PIXEL, 16'h0, 16'h0, 16'h0, 16'h0, 24'h3c3c3c));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_drained();
        write_register(directed_rows[i].cfg_index, directed_rows[i].cfg_data);
      end else begin
        send_item(directed_rows[i].item, directed_rows[i].has_first,
                  directed_rows[i].first_out);
      end
    end
    directed_items = items_sent;

    while (items_sent - directed_items < RAND_ITEMS) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        run_window_sequence();
      end else if (sel < 9) begin
        repeat ($urandom_range(1, 3)) send_item(rand_item(), 1'b0, '0);
      end else begin
        wait_drained();
        write_register(REG_FRAME_WIDTH, pick_frame_dim());
        write_register(REG_FRAME_HEIGHT, pick_frame_dim());
      end
      if (items_sent - directed_items > 30) hold_request = 1'b1;
      if (!paused_once && items_sent - directed_items > 100) begin
        wait_drained();
        paused_once = 1'b1;
      end
    end

    wait_drained();
    if (pending_bytes.size() != 0) report_mismatch("missing transactions", 32'd0,
                                                   32'(pending_bytes.size()));

    $display("Ran %0d directed and %0d random input transactions with %0d register writes;",
             directed_items, items_sent - directed_items, cfg_writes);
    $display("checked %0d output transactions, %0d of them overruns.",
             results_seen, overruns_seen);
    if (err_count == 0) begin
      $display("lcd_window_pixel_stream_core test passed");
    end else begin
      $display("lcd_window_pixel_stream_core test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/lwps_pkg.sv
rtl/lwps_front.sv
rtl/lwps_queue.sv
rtl/lwps_back.sv
rtl/lcd_window_pixel_stream_core.sv
dv/tb_lcd_window_pixel_stream_core.sv
